>>> sv/spq_pkg.sv
package spq_pkg;

    // Field widths fixed by the stream format
    localparam int PRIO_FIELD_W = 8;
    localparam int DATA_FIELD_W = 32;
    localparam int OCC_FIELD_W  = 5;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 48;
    localparam int OUT_TUSER_W  = 2;

    // Default sizing
    localparam int SLOTS_DEF         = 16;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int PAYLOAD_BITS_DEF  = 32;

    // Request kind carried on the input tuser
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_REMOVED  = 2'd2,
        STAT_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUBLISH
    } t_state;

    // Token that walks the cell chain
    typedef struct packed {
        logic active;  // token present at this link
        logic remove;  // request is a remove
        logic hit;     // a cell has taken the insert / offers the current minimum
    } t_scan;

endpackage

>>> sv/spq_cell.sv
module spq_cell #(
    parameter int PRIO_W = spq_pkg::PRIORITY_BITS_DEF,
    parameter int DATA_W = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int IDX_W  = 4,
    parameter int IDX    = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  spq_pkg::t_scan        i_scan,
    input  logic [PRIO_W-1:0]     i_prio,
    input  logic [DATA_W-1:0]     i_data,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic                  i_clr_en,
    input  logic [IDX_W-1:0]      i_clr_idx,
    output spq_pkg::t_scan        o_scan,
    output logic [PRIO_W-1:0]     o_prio,
    output logic [DATA_W-1:0]     o_data,
    output logic [IDX_W-1:0]      o_idx
);

    logic                r_valid;
    logic [PRIO_W-1:0]   r_prio;
    logic [DATA_W-1:0]   r_data;
    spq_pkg::t_scan      r_scan;
    logic [PRIO_W-1:0]   r_co_prio;
    logic [DATA_W-1:0]   r_co_data;
    logic [IDX_W-1:0]    r_co_idx;

    logic                n_valid;
    logic                n_write;
    spq_pkg::t_scan      n_scan;
    logic [PRIO_W-1:0]   n_co_prio;
    logic [DATA_W-1:0]   n_co_data;
    logic [IDX_W-1:0]    n_co_idx;

    always_comb begin
        n_valid   = r_valid;
        n_write   = 1'b0;
        n_scan    = i_scan;
        n_co_prio = i_prio;
        n_co_data = i_data;
        n_co_idx  = i_idx;
        if (i_clr_en && (i_clr_idx == IDX_W'(IDX))) begin
            n_valid = 1'b0;
        end
        if (i_scan.active) begin
            if (!i_scan.remove) begin
                // first free cell on the path claims the entry
                if (!i_scan.hit && !r_valid) begin
                    n_valid    = 1'b1;
                    n_write    = 1'b1;
                    n_scan.hit = 1'b1;
                end
            end else if (r_valid && (!i_scan.hit || (r_prio < i_prio))) begin
                // strictly smaller wins, so ties stay with the lower cell
                n_scan.hit = 1'b1;
                n_co_prio  = r_prio;
                n_co_data  = r_data;
                n_co_idx   = IDX_W'(IDX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_scan  <= '0;
        end else begin
            r_valid <= n_valid;
            r_scan  <= n_scan;
        end
        if (n_write) begin
            r_prio <= i_prio;
            r_data <= i_data;
        end
        r_co_prio <= n_co_prio;
        r_co_data <= n_co_data;
        r_co_idx  <= n_co_idx;
    end

    assign o_scan = r_scan;
    assign o_prio = r_co_prio;
    assign o_data = r_co_data;
    assign o_idx  = r_co_idx;

endmodule

>>> sv/slot_priority_queue_core.sv
// A request enters the launch token, walks the cell chain one cell per cycle, is captured
// at the chain end, then loads the output register; only then is a new request accepted.
// A result held in the output register does not block acceptance of the next request;
// that request's result waits in the publish state until the register drains.
// Reset: synchronous, active low; all slots empty, count zero, both sides idle.
module slot_priority_queue_core #(
    parameter int SLOTS         = spq_pkg::SLOTS_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = spq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [spq_pkg::IN_TDATA_W-1:0]   i_s_tdata,  // priority_req[7:0], payload[39:8]
    input  logic [0:0]                       i_s_tuser,  // action[0]
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [spq_pkg::OUT_TDATA_W-1:0]  o_m_tdata,  // out_priority[7:0], out_payload[39:8],
                                                         // occupancy[44:40], zero[47:45]
    output logic [spq_pkg::OUT_TUSER_W-1:0]  o_m_tuser   // status[1:0]
);

    // Stored widths: the fields are cut to the configured widths
    localparam int PW    = (PRIORITY_BITS < spq_pkg::PRIO_FIELD_W) ?
                           PRIORITY_BITS : spq_pkg::PRIO_FIELD_W;
    localparam int DW    = (PAYLOAD_BITS < spq_pkg::DATA_FIELD_W) ?
                           PAYLOAD_BITS : spq_pkg::DATA_FIELD_W;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    spq_pkg::t_state     r_state;
    spq_pkg::t_state     n_state;

    // Token launched into cell 0
    spq_pkg::t_scan      r_ci_scan;
    logic [PW-1:0]       r_ci_prio;
    logic [DW-1:0]       r_ci_data;

    // Token captured at the chain end
    logic                r_res_remove;
    logic                r_res_hit;
    logic [PW-1:0]       r_res_prio;
    logic [DW-1:0]       r_res_data;
    logic [IDX_W-1:0]    r_res_idx;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    // Output register
    logic                                r_m_tvalid;
    logic [spq_pkg::OUT_TDATA_W-1:0]     r_m_tdata;
    logic [spq_pkg::OUT_TUSER_W-1:0]     r_m_tuser;

    logic                s_accept;
    logic                s_load;
    logic                s_clr_en;
    spq_pkg::t_status    s_status;
    logic [spq_pkg::PRIO_FIELD_W-1:0] s_out_prio;
    logic [spq_pkg::DATA_FIELD_W-1:0] s_out_data;
    logic [63:0]         s_occ_wide;

    // ------------------------------------------------------------------
    // Cell chain: link k feeds cell k, cell k drives link k+1
    // ------------------------------------------------------------------
    spq_pkg::t_scan      w_scan [SLOTS+1];
    logic [PW-1:0]       w_prio [SLOTS+1];
    logic [DW-1:0]       w_data [SLOTS+1];
    logic [IDX_W-1:0]    w_idx  [SLOTS+1];

    assign w_scan[0] = r_ci_scan;
    assign w_prio[0] = r_ci_prio;
    assign w_data[0] = r_ci_data;
    assign w_idx[0]  = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        spq_cell #(
            .PRIO_W (PW),
            .DATA_W (DW),
            .IDX_W  (IDX_W),
            .IDX    (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_scan    (w_scan[g]),
            .i_prio    (w_prio[g]),
            .i_data    (w_data[g]),
            .i_idx     (w_idx[g]),
            .i_clr_en  (s_clr_en),
            .i_clr_idx (r_res_idx),
            .o_scan    (w_scan[g+1]),
            .o_prio    (w_prio[g+1]),
            .o_data    (w_data[g+1]),
            .o_idx     (w_idx[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Handshake and FSM
    // ------------------------------------------------------------------
    assign o_s_tready = (r_state == spq_pkg::ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    // publish once the output register is free or being drained
    assign s_load     = (r_state == spq_pkg::ST_PUBLISH) && (!r_m_tvalid || i_m_tready);
    // free the winning slot of a remove as the result is published
    assign s_clr_en   = s_load && r_res_remove && r_res_hit;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            spq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_state = spq_pkg::ST_SCAN;
                end
            end
            spq_pkg::ST_SCAN: begin
                // wait for the token to fall off the last cell
                if (w_scan[SLOTS].active) begin
                    n_state = spq_pkg::ST_PUBLISH;
                end
            end
            spq_pkg::ST_PUBLISH: begin
                if (s_load) begin
                    n_state = spq_pkg::ST_IDLE;
                    if (r_res_hit) begin
                        n_count = r_res_remove ? (r_count - CNT_W'(1)) : (r_count + CNT_W'(1));
                    end
                end
            end
            default: begin
                n_state = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Launch the token for one cycle on acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci_scan <= '0;
        end else begin
            r_ci_scan.active <= s_accept;
            r_ci_scan.remove <= (i_s_tuser[0] == spq_pkg::ACT_REMOVE);
            r_ci_scan.hit    <= 1'b0;
        end
        if (s_accept) begin
            r_ci_prio <= i_s_tdata[PW-1:0];
            r_ci_data <= i_s_tdata[spq_pkg::PRIO_FIELD_W +: DW];
        end
    end

    // Capture the scan outcome at the chain end
    always_ff @(posedge i_clk) begin
        if ((r_state == spq_pkg::ST_SCAN) && w_scan[SLOTS].active) begin
            r_res_remove <= w_scan[SLOTS].remove;
            r_res_hit    <= w_scan[SLOTS].hit;
            r_res_prio   <= w_prio[SLOTS];
            r_res_data   <= w_data[SLOTS];
            r_res_idx    <= w_idx[SLOTS];
        end
    end

    // ------------------------------------------------------------------
    // Result formatting
    // ------------------------------------------------------------------
    always_comb begin
        if (r_res_remove) begin
            s_status = r_res_hit ? spq_pkg::STAT_REMOVED : spq_pkg::STAT_EMPTY;
        end else begin
            s_status = r_res_hit ? spq_pkg::STAT_INSERTED : spq_pkg::STAT_FULL;
        end
        // drop priority and payload unless an entry actually left the queue
        s_out_prio = '0;
        s_out_data = '0;
        if (r_res_remove && r_res_hit) begin
            s_out_prio[PW-1:0] = r_res_prio;
            s_out_data[DW-1:0] = r_res_data;
        end
        s_occ_wide = 64'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (s_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
        if (s_load) begin
            r_m_tdata <= {3'b000, s_occ_wide[spq_pkg::OCC_FIELD_W-1:0], s_out_data, s_out_prio};
            r_m_tuser <= s_status;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("slot count exceeds capacity");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_load && !r_res_remove && !r_res_hit) |-> (r_count == CNT_W'(SLOTS)))
        else $error("insert refused while a slot is free");

    a_empty_only_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_load && r_res_remove && !r_res_hit) |-> (r_count == '0))
        else $error("remove reported empty while entries are held");

    a_no_stray_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spq_pkg::ST_IDLE) |-> !w_scan[SLOTS].active)
        else $error("scan token reached chain end while idle");
`endif

endmodule
